### sv/fxa_pkg.sv
// ----------------------------------------------------------------------------
// fxa_pkg
// types and constants shared by the q24.8 fixed-point alu
// ----------------------------------------------------------------------------
package fxa_pkg;

   localparam int WW  = 32;          // word width
   localparam int FB  = 8;           // fraction bits
   localparam int NW  = WW + FB;     // dividend width after scaling
   localparam int QW  = NW;          // quotient bits, one per divider stage
   localparam int PW  = 2 * WW;      // product width
   localparam int QSW = PW - FB + 1; // width of the rounded magnitude

   localparam logic signed [WW-1:0] MAXV = {1'b0, {(WW-1){1'b1}}};
   localparam logic signed [WW-1:0] MINV = {1'b1, {(WW-1){1'b0}}};
   localparam logic signed [WW-1:0] ONE  = WW'(1) << FB;

   typedef enum logic [3:0] {
      ACT_ADD      = 4'd0,
      ACT_SUB      = 4'd1,
      ACT_MUL      = 4'd2,
      ACT_DIV      = 4'd3,
      ACT_MIN      = 4'd4,
      ACT_MAX      = 4'd5,
      ACT_INC      = 4'd6,
      ACT_DEC      = 4'd7,
      ACT_TO_INT   = 4'd8,
      ACT_FROM_INT = 4'd9
   } act_type;

   typedef enum logic [1:0] {
      KIND_SIMPLE = 2'd0,
      KIND_MUL    = 2'd1,
      KIND_DIV    = 2'd2
   } kind_type;

   typedef struct packed {
      logic [3:0]           action;
      logic signed [WW-1:0] operand_a;
      logic signed [WW-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [WW-1:0] result;
      logic                 a_less;
      logic                 a_greater;
      logic                 a_equal;
      logic                 overflow;
      logic                 divide_by_zero;
   } rsp_type;

   // one queued word: classified item with its ready-made simple answer
   typedef struct packed {
      kind_type    kind;
      logic        neg;
      logic [WW-1:0] mag_a;
      logic [WW-1:0] mag_b;
      rsp_type     simple;
   } work_type;

endpackage

### sv/fxa_front.sv
// ----------------------------------------------------------------------------
// fxa_front
// decodes a request, works out the simple actions combinationally and classifies the word
// ----------------------------------------------------------------------------
module fxa_front
   import fxa_pkg::*;
(
   input  req_type  req,
   output work_type work
);

   logic signed [WW:0]   sum_c;
   logic signed [WW:0]   lhs_c;
   logic signed [WW:0]   rhs_c;
   logic                 sub_c;
   logic signed [WW-1:0] a_c;
   logic signed [WW-1:0] b_c;
   logic                 less_c;
   logic                 greater_c;
   logic signed [WW-1:0] hi_c;
   logic                 fits_c;

   assign a_c       = req.operand_a;
   assign b_c       = req.operand_b;
   assign less_c    = a_c < b_c;
   assign greater_c = b_c < a_c;
   // bits that a left shift by the fraction width would drop, and the new sign bit
   assign hi_c      = a_c >>> (WW - 1 - FB);
   assign fits_c    = (hi_c == '0) || (hi_c == '1);

   always_comb begin
      lhs_c = {a_c[WW-1], a_c};
      rhs_c = {b_c[WW-1], b_c};
      sub_c = 1'b0;
      unique case (act_type'(req.action))
         ACT_SUB: sub_c = 1'b1;
         ACT_INC: rhs_c = {ONE[WW-1], ONE};
         ACT_DEC: begin
            rhs_c = {ONE[WW-1], ONE};
            sub_c = 1'b1;
         end
         default: sub_c = 1'b0;
      endcase
      sum_c = sub_c ? lhs_c - rhs_c : lhs_c + rhs_c;
   end

   always_comb begin
      work                       = '0;
      work.kind                  = KIND_SIMPLE;
      work.neg                   = a_c[WW-1] ^ b_c[WW-1];
      work.mag_a                 = a_c[WW-1] ? WW'(-a_c) : a_c;
      work.mag_b                 = b_c[WW-1] ? WW'(-b_c) : b_c;
      work.simple.a_less         = less_c;
      work.simple.a_greater      = greater_c;
      work.simple.a_equal        = a_c == b_c;
      unique case (act_type'(req.action))
         ACT_ADD, ACT_SUB, ACT_INC, ACT_DEC: begin
            if (sum_c[WW] != sum_c[WW-1]) begin
               work.simple.overflow = 1'b1;
               work.simple.result   = sum_c[WW] ? MINV : MAXV;
            end else begin
               work.simple.result = sum_c[WW-1:0];
            end
         end
         ACT_MUL: work.kind = KIND_MUL;
         ACT_DIV: begin
            if (b_c == '0) begin
               work.simple.divide_by_zero = 1'b1;
            end else begin
               work.kind = KIND_DIV;
            end
         end
         ACT_MIN:    work.simple.result = greater_c ? b_c : a_c;
         ACT_MAX:    work.simple.result = less_c ? b_c : a_c;
         ACT_TO_INT: work.simple.result = a_c >>> FB;
         ACT_FROM_INT: begin
            if (fits_c) begin
               work.simple.result = a_c <<< FB;
            end else begin
               work.simple.overflow = 1'b1;
               work.simple.result   = a_c[WW-1] ? MINV : MAXV;
            end
         end
         default: work.simple.result = '0;
      endcase
   end

endmodule

### sv/fxa_queue.sv
// ----------------------------------------------------------------------------
// fxa_queue
// short fifo of classified words between front and back
// ----------------------------------------------------------------------------
module fxa_queue
   import fxa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_word,
   input  logic     pop,
   output work_type head,
   output logic     empty,
   output logic     full
);

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   work_type       mem_ff [DEPTH];
   logic [AW-1:0]  wr_ff, wr_in;
   logic [AW-1:0]  rd_ff, rd_in;
   logic [AW:0]    cnt_ff, cnt_in;
   logic           do_push;
   logic           do_pop;

   assign empty   = cnt_ff == '0;
   assign full    = cnt_ff == (AW+1)'(DEPTH);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### sv/fxa_back.sv
// ----------------------------------------------------------------------------
// fxa_back
// multiply and pipelined restoring divide, rounding and saturation
// ----------------------------------------------------------------------------
module fxa_back
   import fxa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  work_type in_word,
   output logic     out_strobe,
   output rsp_type  out_rsp
);

   logic [QW:0]    vld_ff, vld_in;
   work_type       w_ff    [QW+1];
   logic [PW-1:0]  prod_ff [QW+1];
   logic [WW-1:0]  rem_ff  [QW+1];
   logic [QW-1:0]  quot_ff [QW+1];
   work_type       w_in    [QW+1];
   logic [PW-1:0]  prod_in [QW+1];
   logic [WW-1:0]  rem_in  [QW+1];
   logic [QW-1:0]  quot_in [QW+1];
   logic [WW:0]    r2_c    [QW+1];
   logic [NW-1:0]  num_c   [QW+1];
   logic           qb_c    [QW+1];

   logic [QSW-1:0] qsel_c;
   logic [QSW-1:0] qr_c;
   logic           rnd_c;
   logic           strobe_ff;
   rsp_type        rsp_ff, rsp_in;
   work_type       last_c;

   always_comb begin
      vld_in[0]  = in_valid;
      w_in[0]    = in_word;
      prod_in[0] = in_word.mag_a * in_word.mag_b;
      rem_in[0]  = '0;
      quot_in[0] = '0;
      r2_c[0]    = '0;
      num_c[0]   = '0;
      qb_c[0]    = 1'b0;
      // one quotient bit per stage
      for (int i = 1; i <= QW; i++) begin
         num_c[i]   = {w_ff[i-1].mag_a, {FB{1'b0}}};
         r2_c[i]    = {rem_ff[i-1], num_c[i][NW-i]};
         qb_c[i]    = r2_c[i] >= {1'b0, w_ff[i-1].mag_b};
         rem_in[i]  = qb_c[i] ? WW'(r2_c[i] - {1'b0, w_ff[i-1].mag_b}) : r2_c[i][WW-1:0];
         quot_in[i] = {quot_ff[i-1][QW-2:0], qb_c[i]};
         vld_in[i]  = vld_ff[i-1];
         w_in[i]    = w_ff[i-1];
         prod_in[i] = prod_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= QW; i++) begin
         w_ff[i]    <= w_in[i];
         prod_ff[i] <= prod_in[i];
         rem_ff[i]  <= rem_in[i];
         quot_ff[i] <= quot_in[i];
      end
   end

   // round half away from zero on the magnitude, then saturate with sign
   always_comb begin
      last_c = w_ff[QW];
      if (last_c.kind == KIND_MUL) begin
         qsel_c = {1'b0, prod_ff[QW][PW-1:FB]};
         rnd_c  = prod_ff[QW][FB-1];
      end else begin
         qsel_c = QSW'(quot_ff[QW]);
         rnd_c  = {rem_ff[QW], 1'b0} >= {1'b0, last_c.mag_b};
      end
      qr_c   = qsel_c + QSW'(rnd_c);
      rsp_in = last_c.simple;
      if (last_c.kind != KIND_SIMPLE) begin
         if (last_c.neg) begin
            if (qr_c > {{(QSW-WW){1'b0}}, 1'b1, {(WW-1){1'b0}}}) begin
               rsp_in.overflow = 1'b1;
               rsp_in.result   = MINV;
            end else begin
               rsp_in.result = -qr_c[WW-1:0];
            end
         end else begin
            if (qr_c > {{(QSW-WW+1){1'b0}}, {(WW-1){1'b1}}}) begin
               rsp_in.overflow = 1'b1;
               rsp_in.result   = MAXV;
            end else begin
               rsp_in.result = qr_c[WW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         strobe_ff <= vld_ff[QW];
      end
   end

   assign out_strobe = strobe_ff;
   assign out_rsp    = rsp_ff;

endmodule

### sv/fixed_point_q24_8_alu_unit.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_unit
// signed q24.8 alu: add, sub, mul, div, min, max, inc, dec, int conversions
// ----------------------------------------------------------------------------
// usage: drive req with an action and two raw operands and raise start; the
// word is taken at a rising edge with start high and busy low. each word
// gives one result on rsp, valid for exactly one cycle with rsp_strobe high.
// from acceptance to the strobe cycle a word passes through the queue, one
// multiply/load stage, 40 divider stages (one quotient bit each) and the
// rounding/saturation register. every action takes the same path so results
// leave in order.
// throughput: one word per cycle. the back end never stalls, so the queue
// drains every cycle and busy stays low in operation.
// the receiver cannot hold results off; rsp_strobe is simply a pulse.
// reset clears the queue pointers and the pipeline valid bits; words in
// flight are dropped and no strobe follows until new words arrive.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_unit
   import fxa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   output logic    rsp_strobe,
   output rsp_type rsp
);

   work_type front_word;
   work_type head_word;
   logic     q_empty;
   logic     q_full;

   assign busy = q_full;

   fxa_front u_front (
      .req  (req),
      .work (front_word)
   );

   fxa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (start && !busy),
      .push_word (front_word),
      .pop       (!q_empty),
      .head      (head_word),
      .empty     (q_empty),
      .full      (q_full)
   );

   fxa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (!q_empty),
      .in_word    (head_word),
      .out_strobe (rsp_strobe),
      .out_rsp    (rsp)
   );

   a_one_relation: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $onehot({rsp.a_less, rsp.a_greater, rsp.a_equal}))
      else $error("compare flags not exclusive");

   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp.divide_by_zero |-> rsp.result == '0 && !rsp.overflow)
      else $error("zero divisor gave non-zero result");

   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp.overflow |-> rsp.result == MAXV || rsp.result == MINV)
      else $error("overflow without saturated result");

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("queue filled although back end never stalls");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the q24.8 alu against a behavioural predictor of every action, with
// directed corner words, random words with and without gaps, and an idle drain
// ----------------------------------------------------------------------------
module testbench;
   import fxa_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_strobe;
   rsp_type rsp;

   rsp_type expected_q[$];
   int      error_count;
   int      sent_count;
   int      checked_count;
   bit      gaps_on;

   fixed_point_q24_8_alu_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req(req), .rsp_strobe(rsp_strobe), .rsp(rsp)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // saturate a wide signed value to the word
   function automatic rsp_type clamp(input logic signed [127:0] v, input rsp_type r);
      rsp_type o;
      o = r;
      if (v > 128'(signed'(MAXV))) begin
         o.result = MAXV;
         o.overflow = 1'b1;
      end else if (v < 128'(signed'(MINV))) begin
         o.result = MINV;
         o.overflow = 1'b1;
      end else begin
         o.result = v[WW-1:0];
      end
      return o;
   endfunction

   function automatic rsp_type alu_predict(input req_type w);
      rsp_type o;
      logic signed [127:0] a, b, p, q;
      logic [127:0] ma, mb, num, mq, mr;
      a = w.operand_a;
      b = w.operand_b;
      o = '0;
      o.a_less = a < b;
      o.a_greater = a > b;
      o.a_equal = a == b;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      case (w.action)
         ACT_ADD:      o = clamp(a + b, o);
         ACT_SUB:      o = clamp(a - b, o);
         ACT_MUL: begin
            // magnitude product, round half away from zero
            mq = ((ma * mb) + (128'd1 << (FB - 1))) >> FB;
            p = ((a < 0) != (b < 0)) ? -signed'(mq) : signed'(mq);
            o = clamp(p, o);
         end
         ACT_DIV: begin
            if (b == 0) begin
               o.divide_by_zero = 1'b1;
            end else begin
               num = ma << FB;
               mq = num / mb;
               mr = num % mb;
               if (mr >= mb - mr) mq = mq + 1;
               q = ((a < 0) != (b < 0)) ? -signed'(mq) : signed'(mq);
               o = clamp(q, o);
            end
         end
         ACT_MIN:      o.result = (a > b) ? w.operand_b : w.operand_a;
         ACT_MAX:      o.result = (a < b) ? w.operand_b : w.operand_a;
         ACT_INC:      o = clamp(a + (128'sd1 <<< FB), o);
         ACT_DEC:      o = clamp(a - (128'sd1 <<< FB), o);
         ACT_TO_INT:   o.result = w.operand_a >>> FB;
         ACT_FROM_INT: o = clamp(a <<< FB, o);
         default:      o.result = '0;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h (word %0d)", what, got, want,
               checked_count);
      error_count++;
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) @(negedge clock);
   endtask

   task automatic send_word(input logic [3:0] act, input logic [31:0] a,
                            input logic [31:0] b);
      req_type w;
      w.action = act;
      w.operand_a = a;
      w.operand_b = b;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         idle_cycles($urandom_range(1, 10));
      end
      req <= w;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_q.push_back(alu_predict(w));
      sent_count++;
      @(negedge clock);
   endtask

   task automatic end_burst();
      start <= 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result", rsp.result, 32'd0);
         end else begin
            want = expected_q.pop_front();
            if (rsp.result !== want.result)
               report_mismatch("result", rsp.result, want.result);
            if (rsp.a_less !== want.a_less)
               report_mismatch("a_less", rsp.a_less, want.a_less);
            if (rsp.a_greater !== want.a_greater)
               report_mismatch("a_greater", rsp.a_greater, want.a_greater);
            if (rsp.a_equal !== want.a_equal)
               report_mismatch("a_equal", rsp.a_equal, want.a_equal);
            if (rsp.overflow !== want.overflow)
               report_mismatch("overflow", rsp.overflow, want.overflow);
            if (rsp.divide_by_zero !== want.divide_by_zero)
               report_mismatch("divide_by_zero", rsp.divide_by_zero,
                               want.divide_by_zero);
            checked_count++;
         end
      end
   end

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return MAXV - $urandom_range(0, 3);
         1: return MINV + $urandom_range(0, 3);
         2: return $urandom_range(0, 4) - 2;
         3: return $urandom_range(0, 8191) - 4096;
         4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      logic [31:0] corner[6];
      corner = '{MAXV, MINV, 32'd0, 32'hffff_ffff, ONE, 32'h0000_0080};
      foreach (corner[i]) send_word(ACT_MUL, corner[i], corner[(i + 1) % 6]);
      send_word(ACT_DIV, 32'h0000_0500, 32'd0);       // zero divisor
      send_word(ACT_DIV, MINV, 32'hffff_ffff);         // quotient too large
      send_word(ACT_DIV, 32'h0000_0001, 32'h0000_0002);// quotient exactly one half
      send_word(ACT_DIV, 32'hffff_ffff, 32'h0000_0002);
      send_word(ACT_ADD, MAXV, ONE);
      send_word(ACT_SUB, MINV, ONE);
      send_word(ACT_MIN, 32'h1234, 32'h1234);          // equal operands
      send_word(ACT_MAX, MINV, MAXV);
      send_word(ACT_INC, MAXV, 32'd0);
      send_word(ACT_DEC, MINV, 32'd0);
      send_word(ACT_TO_INT, 32'hffff_ff01, 32'd0);
      send_word(ACT_TO_INT, MAXV, MINV);
      send_word(ACT_FROM_INT, 32'h007f_ffff, 32'd0);
      send_word(ACT_FROM_INT, 32'hff80_0000, 32'd0);
      send_word(ACT_FROM_INT, 32'h0080_0000, 32'd0);
      send_word(4'd10, 32'd5, 32'd9);                   // unknown action codes
      send_word(4'd15, 32'd9, 32'd5);
      end_burst();
   endtask

   task automatic test_random(input int n);
      repeat (n) send_word($urandom_range(0, 15) < 14 ? 4'($urandom_range(0, 9))
                           : 4'($urandom_range(10, 15)), rand_operand(), rand_operand());
      end_burst();
   endtask

   task automatic test_drain_pause();
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      start = 1'b0;
      req = '0;
      reset = 1'b1;
      error_count = 0;
      sent_count = 0;
      checked_count = 0;
      gaps_on = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random(500);
      test_drain_pause();
      test_random(500);
      gaps_on = 1'b0;
      test_random(330);
      test_drain_pause();
      idle_cycles(60);
      $display("sent %0d words, checked %0d results: every action, corner operands,",
               sent_count, checked_count);
      $display("random gaps, a full drain mid-run and back-to-back traffic at the end");
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("FAILURE");
      $finish;
   end

endmodule

### sim.f
sv/fxa_pkg.sv
sv/fxa_front.sv
sv/fxa_queue.sv
sv/fxa_back.sv
sv/fixed_point_q24_8_alu_unit.sv
test/testbench.sv
